FILE: src/ttae_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the three-tap echo core.
package ttae_pkg;

    // Delay ring geometry
    localparam int RING_DEPTH = 65536;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // Field widths
    localparam int SAMPLE_W = 8;
    localparam int DELAY_W  = 16;
    localparam int GAIN_W   = 9;
    localparam int NORM_W   = 17;
    localparam int COUNT_W  = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Width for ring address arithmetic: holds RING_DEPTH and any delay
    localparam int CALC_W = ((RING_AW > DELAY_W) ? RING_AW : DELAY_W) + 1;

    // Shared multiplier operands and accumulator
    localparam int OPA_W = 19;
    localparam int OPB_W = 18;
    localparam int ACC_W = OPA_W + OPB_W;
    localparam int SAT_W = ACC_W + 2;

    localparam int OFFSET = 128;
    localparam int FRAC_W = 24;

    // APB register map
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_DELAY_ONE   = 3'd0,
        REG_DELAY_TWO   = 3'd1,
        REG_DELAY_THREE = 3'd2,
        REG_GAIN_ONE    = 3'd3,
        REG_GAIN_TWO    = 3'd4,
        REG_GAIN_THREE  = 3'd5,
        REG_NORM_RECIP  = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD
    } mac_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TAP,
        ST_NORM,
        ST_SAT
    } state_t;

endpackage

FILE: src/ttae_ring.sv
`timescale 1ns / 1ps
// Single-port-write, single-port-read RAM with registered read data.
module ttae_ring #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/ttae_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: acc = a*b, acc + a*b, or holds its value.
module ttae_mac
    import ttae_pkg::*;
(
    input  logic                    clk,
    input  mac_op_t                 op,
    input  logic signed [OPA_W-1:0] op_a,
    input  logic signed [OPB_W-1:0] op_b,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] product;

    assign product = op_a * op_b;

    always_comb
    begin
        case (op)
            MAC_LOAD: acc_next = product;
            MAC_ADD:  acc_next = acc_reg + product;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

FILE: src/three_tap_audio_echo_core.sv
`timescale 1ns / 1ps
// Three-tap echo core: sequencer, register file, delay ring and shared MAC.
//
// Three-tap echo on 8-bit offset-binary audio. Each accepted word is written
// into a 65536-entry delay ring; the result is the centred dry sample times
// 1.0 plus three centred delayed samples, each times its own Q1.8 gain, all
// multiplied by the Q1.16 normaliser from software, re-offset by 128,
// truncated and clamped to 0..255. A tap only contributes once the position
// within the current block has reached its delay; tlast on the input ends a
// block and the count restarts with the next word. Each word is accepted and
// written into the ring, then the dry-term load, the three tap additions (ring
// reads overlapped with the multiply-accumulate) and the normalising multiply
// run, all on the single shared multiplier; once the output register is free,
// the result is clamped into it. The input side is not ready while a word is
// being worked on. Registers are to be written over APB while the core is
// idle; the core does not enforce this, and the ring needs no clearing pass.
module three_tap_audio_echo_core
    import ttae_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave side
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] sample_in
    input  logic                 s_tlast,   // last_sample
    // master side
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] sample_out
    output logic                 m_tlast,   // last_out
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [DELAY_W-1:0] delay_reg [3];
    logic [GAIN_W-1:0]  gain_reg  [3];
    logic [NORM_W-1:0]  norm_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg[0] <= DELAY_W'(14666);
            delay_reg[1] <= DELAY_W'(22000);
            delay_reg[2] <= DELAY_W'(44000);
            gain_reg[0]  <= GAIN_W'(128);
            gain_reg[1]  <= GAIN_W'(102);
            gain_reg[2]  <= GAIN_W'(77);
            norm_reg     <= NORM_W'(29789);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DELAY_ONE:   delay_reg[0] <= pwdata[DELAY_W-1:0];
                REG_DELAY_TWO:   delay_reg[1] <= pwdata[DELAY_W-1:0];
                REG_DELAY_THREE: delay_reg[2] <= pwdata[DELAY_W-1:0];
                REG_GAIN_ONE:    gain_reg[0]  <= pwdata[GAIN_W-1:0];
                REG_GAIN_TWO:    gain_reg[1]  <= pwdata[GAIN_W-1:0];
                REG_GAIN_THREE:  gain_reg[2]  <= pwdata[GAIN_W-1:0];
                REG_NORM_RECIP:  norm_reg     <= pwdata[NORM_W-1:0];
                default: ;      // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_DELAY_ONE:   prdata = PDATA_W'(delay_reg[0]);
            REG_DELAY_TWO:   prdata = PDATA_W'(delay_reg[1]);
            REG_DELAY_THREE: prdata = PDATA_W'(delay_reg[2]);
            REG_GAIN_ONE:    prdata = PDATA_W'(gain_reg[0]);
            REG_GAIN_TWO:    prdata = PDATA_W'(gain_reg[1]);
            REG_GAIN_THREE:  prdata = PDATA_W'(gain_reg[2]);
            REG_NORM_RECIP:  prdata = PDATA_W'(norm_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [1:0]          tap_cnt_reg, tap_cnt_next;
    logic [RING_AW-1:0]  wp_reg, wp_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                last_reg, last_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    logic                accept;

    // ring
    logic                rd_en;
    logic [1:0]          rd_tap;
    logic [RING_AW-1:0]  rd_addr;
    logic [SAMPLE_W-1:0] rd_data;

    // shared MAC
    mac_op_t                 mac_op;
    logic signed [OPA_W-1:0] op_a;
    logic signed [OPB_W-1:0] op_b;
    logic signed [ACC_W-1:0] acc;

    // tap being accumulated this cycle
    logic [DELAY_W-1:0]  mac_delay;
    logic [GAIN_W-1:0]   mac_gain;
    logic                mac_in_reach;

    // clamp
    logic signed [SAT_W-1:0] biased;
    logic [SAMPLE_W-1:0]     clamped;

    // ring read address: wp - delay, wrapped into the ring
    logic [DELAY_W-1:0] rd_delay;
    logic [CALC_W-1:0]  wp_ext, dly_ext, diff;

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        rd_delay = delay_reg[rd_tap];
        wp_ext   = CALC_W'(wp_reg);
        dly_ext  = CALC_W'(rd_delay);
        if (wp_ext >= dly_ext)
        begin
            diff = wp_ext - dly_ext;
        end
        else
        begin
            diff = wp_ext + CALC_W'(RING_DEPTH) - dly_ext;
        end
        rd_addr = diff[RING_AW-1:0];
    end

    // tap gating: within the block and held by the ring
    always_comb
    begin
        mac_delay    = delay_reg[tap_cnt_reg];
        mac_gain     = gain_reg[tap_cnt_reg];
        mac_in_reach = (COUNT_W'(mac_delay) <= count_reg)
                    && (CALC_W'(mac_delay) < CALC_W'(RING_DEPTH));
    end

    // offset, floor and clamp of the normalised product
    always_comb
    begin
        biased = SAT_W'(acc) + (SAT_W'(OFFSET) <<< FRAC_W);
        if (biased[SAT_W-1])
        begin
            clamped = '0;
        end
        else if (|biased[SAT_W-2:FRAC_W+SAMPLE_W])
        begin
            clamped = {SAMPLE_W{1'b1}};
        end
        else
        begin
            clamped = biased[FRAC_W+SAMPLE_W-1:FRAC_W];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        tap_cnt_next  = tap_cnt_reg;
        wp_next       = wp_reg;
        count_next    = count_reg;
        sample_next   = sample_reg;
        last_next     = last_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        rd_en         = 1'b0;
        rd_tap        = tap_cnt_reg;
        mac_op        = MAC_HOLD;
        op_a          = '0;
        op_b          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    sample_next = s_tdata;
                    last_next   = s_tlast;
                    state_next  = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                // dry term times 1.0 (256 in Q8); first ring read
                mac_op       = MAC_LOAD;
                op_a         = OPA_W'($signed({1'b0, sample_reg})) - OPA_W'(OFFSET);
                op_b         = OPB_W'(256);
                rd_en        = 1'b1;
                rd_tap       = 2'd0;
                tap_cnt_next = 2'd0;
                state_next   = ST_TAP;
            end

            ST_TAP:
            begin
                if (mac_in_reach)
                begin
                    mac_op = MAC_ADD;
                end
                op_a = OPA_W'($signed({1'b0, rd_data})) - OPA_W'(OFFSET);
                op_b = OPB_W'($signed({1'b0, mac_gain}));
                if (tap_cnt_reg == 2'd2)
                begin
                    state_next = ST_NORM;
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_tap       = tap_cnt_reg + 2'd1;
                    tap_cnt_next = tap_cnt_reg + 2'd1;
                end
            end

            ST_NORM:
            begin
                mac_op     = MAC_LOAD;
                op_a       = acc[OPA_W-1:0];
                op_b       = OPB_W'($signed({1'b0, norm_reg}));
                state_next = ST_SAT;
            end

            ST_SAT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = clamped;
                    m_tlast_next  = last_reg;
                    wp_next = (wp_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    if (last_reg)
                    begin
                        count_next = '0;
                    end
                    else if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tap_cnt_reg  <= '0;
            wp_reg       <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tap_cnt_reg  <= tap_cnt_next;
            wp_reg       <= wp_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        last_reg    <= last_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------
    // Delay ring and shared MAC
    // ---------------------------------------------------------------
    ttae_ring #(
        .DEPTH (RING_DEPTH),
        .WIDTH (SAMPLE_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ttae_mac u_mac (
        .clk  (clk),
        .op   (mac_op),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken again straight after a word");

    a_tap_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP) |-> (tap_cnt_reg != 2'd3))
        else $error("tap counter out of range");

    a_sat_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAT && m_tvalid && !m_tready) |=> (state_reg == ST_SAT))
        else $error("result dropped while output stalled");

    a_wp_moves_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SAT) |=> $stable(wp_reg))
        else $error("write pointer moved outside result stage");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-tap echo core: stream and APB stimulus, echo predictor.
module testbench;
    import ttae_pkg::*;

    // Address with no register behind it; writes there must leave the map alone
    localparam logic [PADDR_W-1:0] REG_UNUSED_ADDR = 5'd28;
    // Cycles with nothing accepted on any port before the run is abandoned
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // Quiet cycles allowed after the last result before touching registers
    localparam int unsigned SETTLE_CYCLES = 12;
    // Mismatch lines printed before going quiet (counting carries on)
    localparam int unsigned REPORT_CAP = 40;
    // Long block: enough words for every tap of that test to come into reach
    localparam int unsigned LONG_BLOCK_WORDS = 64;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                lst;
    } echo_word_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Stream side, driven from the start of the run
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;   // [7:0] sample_in
    logic                s_tlast  = 1'b0; // last_sample
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;         // [7:0] sample_out
    logic                m_tlast;         // last_out

    // APB side
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Predictor state: own copy of the ring, pointer, block position and registers
    logic [SAMPLE_W-1:0] echo_ring [RING_DEPTH];
    logic [RING_AW-1:0]  echo_wr_ptr    = '0;
    logic [COUNT_W-1:0]  echo_blk_count = '0;
    logic [DELAY_W-1:0]  tap_delay [3]  = '{16'd14666, 16'd22000, 16'd44000};
    logic [GAIN_W-1:0]   tap_gain  [3]  = '{9'd128, 9'd102, 9'd77};
    logic [NORM_W-1:0]   norm_recip     = 17'd29789;

    echo_word_t  expected_words [$];
    int unsigned fail_count    = 0;
    bit          idle_on       = 1'b1;
    int unsigned quiet_cycles  = 0;

    always #4 clk = ~clk;

    three_tap_audio_echo_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Echo predictor. Works out the output word for one accepted input
    // word and advances the ring, pointer and block position.
    // ------------------------------------------------------------------
    function automatic echo_word_t echo_predict(input logic [SAMPLE_W-1:0] smp,
                                                input logic lst);
        longint             acc;
        longint             prod;
        logic [RING_AW-1:0] pos;
        echo_word_t         w;
        echo_ring[echo_wr_ptr] = smp;
        // dry term at unity gain
        acc = (longint'(smp) - OFFSET) * 256;
        // A tap only counts once the block has reached its delay; zero delay
        // picks up the word just written. Delays are 16 bit, so none can
        // reach past the ring.
        for (int t = 0; t < 3; t++)
        begin
            if (echo_blk_count >= tap_delay[t])
            begin
                pos = echo_wr_ptr - tap_delay[t];
                acc += (longint'(echo_ring[pos]) - OFFSET) * longint'(tap_gain[t]);
            end
        end
        prod = acc * longint'(norm_recip) + (longint'(OFFSET) << FRAC_W);
        // clamp into offset-binary range
        if (prod < 0)
            w.smp = '0;
        else if ((prod >>> FRAC_W) > 255)
            w.smp = 8'd255;
        else
            w.smp = SAMPLE_W'(prod >>> FRAC_W);
        w.lst = lst;
        echo_wr_ptr = echo_wr_ptr + 1'b1;
        if (lst)
            echo_blk_count = '0;
        else if (echo_blk_count != COUNT_MAX)
            echo_blk_count = echo_blk_count + 1'b1;
        return w;
    endfunction

    function automatic logic [PDATA_W-1:0] reg_shadow(input reg_idx_t idx);
        case (idx)
            REG_DELAY_ONE:   return PDATA_W'(tap_delay[0]);
            REG_DELAY_TWO:   return PDATA_W'(tap_delay[1]);
            REG_DELAY_THREE: return PDATA_W'(tap_delay[2]);
            REG_GAIN_ONE:    return PDATA_W'(tap_gain[0]);
            REG_GAIN_TWO:    return PDATA_W'(tap_gain[1]);
            REG_GAIN_THREE:  return PDATA_W'(tap_gain[2]);
            default:         return PDATA_W'(norm_recip);
        endcase
    endfunction

    // Normaliser that keeps unity overall gain for the given tap gains
    function automatic logic [NORM_W-1:0] unity_norm(input int unsigned g1,
                                                     input int unsigned g2,
                                                     input int unsigned g3);
        return NORM_W'((65536 * 256) / (256 + g1 + g2 + g3));
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd128;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        if (fail_count < REPORT_CAP)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // APB: setup cycle, then access until pready; psel then goes low and is seen
    // low before returning, so back-to-back transfers never touch psel twice in a step.
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] unused;
        apb_access(1'b1, {idx, 2'b00}, val, unused);
        case (idx)
            REG_DELAY_ONE:   tap_delay[0] = val[DELAY_W-1:0];
            REG_DELAY_TWO:   tap_delay[1] = val[DELAY_W-1:0];
            REG_DELAY_THREE: tap_delay[2] = val[DELAY_W-1:0];
            REG_GAIN_ONE:    tap_gain[0]  = val[GAIN_W-1:0];
            REG_GAIN_TWO:    tap_gain[1]  = val[GAIN_W-1:0];
            REG_GAIN_THREE:  tap_gain[2]  = val[GAIN_W-1:0];
            default:         norm_recip   = val[NORM_W-1:0];
        endcase
    endtask

    task automatic set_echo(input int unsigned d1, input int unsigned d2,
                            input int unsigned d3, input int unsigned g1,
                            input int unsigned g2, input int unsigned g3,
                            input int unsigned nr);
        write_reg(REG_DELAY_ONE,   d1);
        write_reg(REG_DELAY_TWO,   d2);
        write_reg(REG_DELAY_THREE, d3);
        write_reg(REG_GAIN_ONE,    g1);
        write_reg(REG_GAIN_TWO,    g2);
        write_reg(REG_GAIN_THREE,  g3);
        write_reg(REG_NORM_RECIP,  nr);
    endtask

    task automatic check_all_regs();
        logic [PDATA_W-1:0] got;
        for (int i = REG_DELAY_ONE; i <= REG_NORM_RECIP; i++)
        begin
            apb_access(1'b0, {reg_idx_t'(i), 2'b00}, '0, got);
            if (got !== reg_shadow(reg_idx_t'(i)))
                note_mismatch("register readback", reg_shadow(reg_idx_t'(i)), got);
        end
    endtask

    // ------------------------------------------------------------------
    // Stream sender: random gap, then hold the word until accepted. With
    // no gap tvalid simply stays high for the next word.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic lst);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        expected_words.push_back(echo_predict(smp, lst));
    endtask

    // Drop tvalid, wait for every result, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall per word, compare each accepted word with
    // the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        echo_word_t  want;
        int unsigned hold;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                    note_mismatch("unexpected word, sample_out", -1, m_tdata);
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want.smp)
                        note_mismatch("sample_out", want.smp, m_tdata);
                    if (m_tlast !== want.lst)
                        note_mismatch("last_out", want.lst, m_tlast);
                end
                hold     = idle_on ? $urandom_range(0, 14) : 0;
                m_tready <= (hold == 0);
            end
            else if (hold != 0)
            begin
                hold     = hold - 1;
                m_tready <= (hold == 0);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles where no port moves anything
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers come up at their reset values; a short block runs on them
    // (all taps far out of reach, so the dry word passes at the normaliser).
    task automatic test_reset_values();
        check_all_regs();
        send_word(8'd0, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd128, 1'b0);
        send_word(8'd77, 1'b1);
        settle();
    endtask

    task automatic test_directed();
        logic [PDATA_W-1:0] unused;
        // Full gains with unity normaliser: zero delay doubles the dry word,
        // short taps come into reach one word at a time, output clamps.
        set_echo(0, 1, 2, 256, 256, 256, 65536);
        check_all_regs();
        send_word(8'd255, 1'b0);
        send_word(8'd0, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd0, 1'b0);
        send_word(8'd128, 1'b1);
        settle();
        // Quarter normaliser keeps the sum in range; block restarts so the
        // one- and three-word taps drop out again at its start.
        set_echo(0, 1, 3, 256, 256, 256, 16384);
        send_word(8'd0, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd128, 1'b0);
        send_word(8'd1, 1'b0);
        send_word(8'd254, 1'b1);
        settle();
        // No gain and no normaliser: every word comes out as silence
        set_echo(0, 0, 0, 0, 0, 0, 0);
        send_word(8'd255, 1'b0);
        send_word(8'd0, 1'b0);
        send_word(8'd200, 1'b1);
        settle();
        // Write to an unused address must leave the map alone
        apb_access(1'b1, REG_UNUSED_ADDR, 32'hFFFF_FFFF, unused);
        check_all_regs();
        // Top-end register values, taps out of reach
        set_echo(65535, 65535, 65535, 255, 255, 255, 65535);
        check_all_regs();
        send_word(8'd255, 1'b0);
        send_word(8'd0, 1'b0);
        send_word(8'd129, 1'b1);
        settle();
    endtask

    task automatic pick_echo_setting();
        int unsigned d [3];
        int unsigned g [3];
        int unsigned nr;
        int unsigned r;
        for (int t = 0; t < 3; t++)
        begin
            r = $urandom_range(0, 19);
            if (r < 14)
                d[t] = $urandom_range(0, 48);
            else if (r < 17)
                d[t] = $urandom_range(0, 65535);
            else
                d[t] = (r == 17) ? 0 : 65535;
            r = $urandom_range(0, 9);
            g[t] = (r == 0) ? 0 : (r == 1) ? 256 : (r == 2) ? 255 : $urandom_range(0, 256);
        end
        r = $urandom_range(0, 9);
        if (r < 6)
            nr = unity_norm(g[0], g[1], g[2]);
        else if (r == 6)
            nr = 65536;
        else if (r == 7)
            nr = 65535;
        else
            nr = $urandom_range(0, 65536);
        set_echo(d[0], d[1], d[2], g[0], g[1], g[2], nr);
    endtask

    // Random settings per phase; mostly long blocks so taps come into
    // reach, one phase of short broken blocks, one phase with no idling.
    task automatic test_random_blocks();
        int unsigned last_odds;
        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            pick_echo_setting();
            idle_on   = (phase != 3);
            last_odds = (phase == 5) ? 4 : 24;
            for (int n = 0; n < 40; n++)
                send_word(pick_sample(), ($urandom_range(1, last_odds) == 1));
        end
        settle();
        idle_on = 1'b1;
    endtask

    // One unbroken block, words back to back, long enough for every tap to
    // come into reach one after another.
    task automatic test_long_block();
        int unsigned g1;
        int unsigned g2;
        int unsigned g3;
        g1 = $urandom_range(0, 256);
        g2 = $urandom_range(0, 256);
        g3 = $urandom_range(0, 256);
        set_echo(60, 31, 3, g1, g2, g3, unity_norm(g1, g2, g3));
        idle_on = 1'b0;
        for (int unsigned n = 0; n < LONG_BLOCK_WORDS; n++)
            send_word(pick_sample(), (n == LONG_BLOCK_WORDS - 1));
        settle();
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed();
        test_random_blocks();
        test_long_block();
        settle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
